// ===== sv/ps2m_pkg.sv =====
// shared types and constants for the ps2 mouse receiver
package ps2m_pkg;

    localparam int GAP_W       = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 1;
    localparam int POS_W       = 4;
    localparam int PKT_IDX_W   = 2;
    localparam int MOVE_W      = 9;

    localparam int MID_DEPTH_DEFAULT = 2;
    localparam int OUT_DEPTH_DEFAULT = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_GAP  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DECODE_EN  = 1'd1;

    localparam logic [GAP_W-1:0] FRAME_GAP_RESET  = 16'd200;
    localparam logic             DECODE_EN_RESET  = 1'b1;

    localparam logic [POS_W-1:0] POS_START  = 4'd0;
    localparam logic [POS_W-1:0] POS_FIRST  = 4'd1;
    localparam logic [POS_W-1:0] POS_LAST   = 4'd8;
    localparam logic [POS_W-1:0] POS_PARITY = 4'd9;
    localparam logic [POS_W-1:0] POS_STOP   = 4'd10;

    localparam int SYNC_BIT   = 3;
    localparam int X_SIGN_BIT = 4;
    localparam int Y_SIGN_BIT = 5;
    localparam int LEFT_BIT   = 0;
    localparam int RIGHT_BIT  = 1;
    localparam int MIDDLE_BIT = 2;

    localparam logic [PKT_IDX_W-1:0] PKT_FIRST  = 2'd0;
    localparam logic [PKT_IDX_W-1:0] PKT_SECOND = 2'd1;
    localparam logic [PKT_IDX_W-1:0] PKT_THIRD  = 2'd2;

    typedef struct packed {
        logic [7:0] value;
        logic       parity_ok;
    } byte_word_t;

    typedef struct packed {
        logic [7:0]               byte_value;
        logic                     parity_ok;
        logic                     packet_valid;
        logic                     left_button;
        logic                     right_button;
        logic                     middle_button;
        logic signed [MOVE_W-1:0] move_x;
        logic signed [MOVE_W-1:0] move_y;
    } result_t;

endpackage

// ===== sv/ps2_mouse_frame_and_packet_receiver.sv =====
// top level of the ps2 mouse frame and packet receiver
// Each word pushed in is one falling edge of the ps2 clock: the sampled data
// level and the microseconds since the previous edge. The block takes one edge
// every cycle while full is low and processes it in the cycle it is pushed.
// The frame stage hands each completed byte to a byte queue of MID_DEPTH words;
// the packet stage drains it at one byte per cycle into a result queue of
// OUT_DEPTH words unless that queue is full; each byte passes through both
// queues in turn. full rises only when both queues are backed up because
// results are not being popped. A result word is produced for every stop-bit
// edge; packet fields are zero unless packet_valid is set.
module ps2_mouse_frame_and_packet_receiver #(
    parameter int MID_DEPTH = ps2m_pkg::MID_DEPTH_DEFAULT,
    parameter int OUT_DEPTH = ps2m_pkg::OUT_DEPTH_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [ps2m_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [ps2m_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              push,
    output logic                              full,
    input  logic                              data_bit,
    input  logic [ps2m_pkg::GAP_W-1:0]        gap_us,
    output logic                              empty,
    input  logic                              pop,
    output logic [7:0]                        byte_value,
    output logic                              parity_ok,
    output logic                              packet_valid,
    output logic                              left_button,
    output logic                              right_button,
    output logic                              middle_button,
    output logic signed [ps2m_pkg::MOVE_W-1:0] move_x,
    output logic signed [ps2m_pkg::MOVE_W-1:0] move_y
);

    import ps2m_pkg::*;

    logic [GAP_W-1:0] frame_gap_reg, frame_gap_next;
    logic             byte_push, byte_full, byte_pop, byte_empty;
    byte_word_t       byte_in, byte_out;
    logic             res_push, res_full;
    result_t          res_in, res_out;

    always_comb
    begin
        frame_gap_next = frame_gap_reg;
        if (cfg_write && cfg_index == REG_FRAME_GAP)
        begin
            frame_gap_next = cfg_data[GAP_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_gap_reg <= FRAME_GAP_RESET;
        end
        else
        begin
            frame_gap_reg <= frame_gap_next;
        end
    end

    ps2m_frame u_frame (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame_gap_us (frame_gap_reg),
        .push         (push),
        .data_bit     (data_bit),
        .gap_us       (gap_us),
        .full         (full),
        .byte_push    (byte_push),
        .byte_word    (byte_in),
        .byte_full    (byte_full)
    );

    ps2m_fifo #(
        .DEPTH  (MID_DEPTH),
        .word_t (byte_word_t)
    ) u_byte_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (byte_push),
        .din   (byte_in),
        .full  (byte_full),
        .pop   (byte_pop),
        .dout  (byte_out),
        .empty (byte_empty)
    );

    ps2m_packet u_packet (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_decode_sel (cfg_index == REG_DECODE_EN),
        .cfg_decode_val (cfg_data[0]),
        .byte_empty     (byte_empty),
        .byte_word      (byte_out),
        .byte_pop       (byte_pop),
        .res_push       (res_push),
        .res_word       (res_in),
        .res_full       (res_full)
    );

    ps2m_fifo #(
        .DEPTH  (OUT_DEPTH),
        .word_t (result_t)
    ) u_result_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .din   (res_in),
        .full  (res_full),
        .pop   (pop),
        .dout  (res_out),
        .empty (empty)
    );

    assign byte_value    = res_out.byte_value;
    assign parity_ok     = res_out.parity_ok;
    assign packet_valid  = res_out.packet_valid;
    assign left_button   = res_out.left_button;
    assign right_button  = res_out.right_button;
    assign middle_button = res_out.middle_button;
    assign move_x        = res_out.move_x;
    assign move_y        = res_out.move_y;

endmodule

// ===== sv/ps2m_fifo.sv =====
// small first-in first-out queue of words
module ps2m_fifo #(
    parameter int  DEPTH  = 2,
    parameter type word_t = logic
) (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  word_t din,
    output logic  full,
    input  logic  pop,
    output word_t dout,
    output logic  empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    word_t              mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

// ===== sv/ps2m_frame.sv =====
// front end: bit framing of ps2 edges into bytes with parity flag
module ps2m_frame (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [ps2m_pkg::GAP_W-1:0] frame_gap_us,
    input  logic                       push,
    input  logic                       data_bit,
    input  logic [ps2m_pkg::GAP_W-1:0] gap_us,
    output logic                       full,
    output logic                       byte_push,
    output ps2m_pkg::byte_word_t       byte_word,
    input  logic                       byte_full
);

    import ps2m_pkg::*;

    logic [POS_W-1:0] bit_pos_reg, bit_pos_next;
    logic [7:0]       shift_reg, shift_next;
    logic             parity_reg, parity_next;
    logic [POS_W-1:0] pos;
    logic [2:0]       bit_idx;
    logic             accept;
    logic             emit;

    assign full    = byte_full;
    assign accept  = push && !byte_full;
    assign pos     = (gap_us > frame_gap_us) ? POS_START : bit_pos_reg;
    assign bit_idx = 3'(pos - POS_FIRST);
    assign emit    = (pos >= POS_STOP);

    assign byte_push           = accept && emit;
    assign byte_word.value     = shift_reg;
    assign byte_word.parity_ok = parity_reg;

    always_comb
    begin
        bit_pos_next = bit_pos_reg;
        shift_next   = shift_reg;
        parity_next  = parity_reg;
        if (accept)
        begin
            bit_pos_next = pos;
            if (pos == POS_START)
            begin
                if (!data_bit)
                begin
                    shift_next   = '0;
                    parity_next  = 1'b0;
                    bit_pos_next = POS_FIRST;
                end
            end
            else if (pos <= POS_LAST)
            begin
                shift_next[bit_idx] = data_bit;
                parity_next         = parity_reg ^ data_bit;
                bit_pos_next        = pos + 1'b1;
            end
            else if (pos == POS_PARITY)
            begin
                parity_next  = parity_reg ^ data_bit;
                bit_pos_next = POS_STOP;
            end
            else
            begin
                bit_pos_next = POS_START;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_pos_reg <= POS_START;
            shift_reg   <= '0;
            parity_reg  <= 1'b0;
        end
        else
        begin
            bit_pos_reg <= bit_pos_next;
            shift_reg   <= shift_next;
            parity_reg  <= parity_next;
        end
    end

endmodule

// ===== sv/ps2m_packet.sv =====
// back end: assembles bytes into three-byte mouse packets
module ps2m_packet (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic                 cfg_decode_sel,
    input  logic                 cfg_decode_val,
    input  logic                 byte_empty,
    input  ps2m_pkg::byte_word_t byte_word,
    output logic                 byte_pop,
    output logic                 res_push,
    output ps2m_pkg::result_t    res_word,
    input  logic                 res_full
);

    import ps2m_pkg::*;

    logic                 decode_en_reg, decode_en_next;
    logic [PKT_IDX_W-1:0] pkt_idx_reg, pkt_idx_next;
    logic [7:0]           store0_reg, store0_next;
    logic [7:0]           store1_reg, store1_next;
    logic                 take;
    logic [7:0]           b;

    assign take     = !byte_empty && !res_full;
    assign byte_pop = take;
    assign res_push = take;
    assign b        = byte_word.value;

    always_comb
    begin
        decode_en_next = decode_en_reg;
        pkt_idx_next   = pkt_idx_reg;
        store0_next    = store0_reg;
        store1_next    = store1_reg;

        res_word            = '0;
        res_word.byte_value = b;
        res_word.parity_ok  = byte_word.parity_ok;

        if (cfg_write && cfg_decode_sel)
        begin
            decode_en_next = cfg_decode_val;
            if (!cfg_decode_val)
            begin
                pkt_idx_next = PKT_FIRST;
            end
        end

        if (take)
        begin
            if (!decode_en_reg)
            begin
                pkt_idx_next = PKT_FIRST;
            end
            else if (pkt_idx_reg == PKT_FIRST && !b[SYNC_BIT])
            begin
                pkt_idx_next = PKT_FIRST;
            end
            else if (pkt_idx_reg == PKT_FIRST)
            begin
                store0_next  = b;
                pkt_idx_next = PKT_SECOND;
            end
            else if (pkt_idx_reg == PKT_SECOND)
            begin
                store1_next  = b;
                pkt_idx_next = PKT_THIRD;
            end
            else
            begin
                pkt_idx_next           = PKT_FIRST;
                res_word.packet_valid  = 1'b1;
                res_word.left_button   = store0_reg[LEFT_BIT];
                res_word.right_button  = store0_reg[RIGHT_BIT];
                res_word.middle_button = store0_reg[MIDDLE_BIT];
                res_word.move_x        = {store0_reg[X_SIGN_BIT], store1_reg};
                res_word.move_y        = {store0_reg[Y_SIGN_BIT], b};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decode_en_reg <= DECODE_EN_RESET;
            pkt_idx_reg   <= PKT_FIRST;
        end
        else
        begin
            decode_en_reg <= decode_en_next;
            pkt_idx_reg   <= pkt_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        store0_reg <= store0_next;
        store1_reg <= store1_next;
    end

endmodule
